/* hdl/rdcw_pkg.sv */
package rdcw_pkg;

  localparam int unsigned ARRAY_SIZE_DEF = 1024;
  localparam int unsigned VALUE_BITS_DEF = 16;

  // Widths of the request and result fields.
  localparam int unsigned POS_FIELD_W   = 10;
  localparam int unsigned VALUE_FIELD_W = 16;
  localparam int unsigned COUNT_FIELD_W = 11;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_e;

  typedef enum logic {
    CNT_ADD    = 1'b0,
    CNT_REMOVE = 1'b1
  } cnt_op_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WSTART,
    S_WALK,
    S_ELEM,
    S_OCC,
    S_WADD,
    S_OUT
  } state_e;

endpackage

/* hdl/range_distinct_count_window.sv */
// A write outside the window passes from S_WSTART back to S_IDLE; one inside it
// goes on through S_ELEM, S_OCC, S_WADD and S_OCC again. A query runs S_WALK,
// S_ELEM and S_OCC for each position the window edges move, then S_OUT. The step
// cost is the element store read followed by an occurrence read-modify-write.
// One request is in work at a time; a finished result may wait in the output
// register while the next request is taken.
// Reset clears the window and the distinct total, then a clearing pass writes
// zero to all 2^VALUE_BITS occurrence entries, one per cycle, before any beat.
module range_distinct_count_window #(
  parameter int unsigned ARRAY_SIZE = rdcw_pkg::ARRAY_SIZE_DEF,
  parameter int unsigned VALUE_BITS = rdcw_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic [rdcw_pkg::POS_FIELD_W-1:0]    position_i,
  input  logic [rdcw_pkg::VALUE_FIELD_W-1:0]  new_value_i,
  input  logic [rdcw_pkg::POS_FIELD_W-1:0]    range_left_i,
  input  logic [rdcw_pkg::POS_FIELD_W-1:0]    range_right_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rdcw_pkg::COUNT_FIELD_W-1:0]  distinct_count_o
);

  // PW indexes the element store, CW holds a window end, a count or a total.
  localparam int unsigned PW  = $clog2(ARRAY_SIZE);
  localparam int unsigned CW  = $clog2(ARRAY_SIZE + 1);
  localparam int unsigned XW0 = (CW > rdcw_pkg::POS_FIELD_W + 1) ? CW
                                                                 : rdcw_pkg::POS_FIELD_W + 1;
  localparam int unsigned XW  = (XW0 > rdcw_pkg::COUNT_FIELD_W) ? XW0
                                                                : rdcw_pkg::COUNT_FIELD_W;
  localparam int unsigned NW  = (VALUE_BITS > rdcw_pkg::VALUE_FIELD_W) ? VALUE_BITS
                                                                       : rdcw_pkg::VALUE_FIELD_W;
  localparam int unsigned VALUE_COUNT = 2 ** VALUE_BITS;

  rdcw_pkg::state_e state_q, state_d;

  logic [VALUE_BITS-1:0] clr_idx_q, clr_idx_d;
  logic                  is_query_q, is_query_d;
  logic [PW-1:0]         pos_q, pos_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [PW-1:0]         lo_q, lo_d;
  logic [CW-1:0]         end_q, end_d;
  logic                  res_zero_q, res_zero_d;
  logic [PW-1:0]         win_low_q, win_low_d;
  logic [CW-1:0]         win_end_q, win_end_d;
  logic [CW-1:0]         total_q, total_d;
  rdcw_pkg::cnt_op_e     op_q, op_d;
  logic [VALUE_BITS-1:0] cur_val_q, cur_val_d;
  logic                  out_valid_q, out_valid_d;
  logic [rdcw_pkg::COUNT_FIELD_W-1:0] dcount_q, dcount_d;

  // Memory ports.
  logic                  elem_we;
  logic [PW-1:0]         elem_waddr;
  logic [VALUE_BITS-1:0] elem_wdata;
  logic [PW-1:0]         elem_raddr;
  logic [VALUE_BITS-1:0] elem_rdata;
  logic                  occ_we;
  logic [VALUE_BITS-1:0] occ_waddr;
  logic [CW-1:0]         occ_wdata;
  logic [VALUE_BITS-1:0] occ_raddr;
  logic [CW-1:0]         occ_rdata;

  // Shared count update unit.
  logic [CW-1:0] unit_cnt;
  logic [CW-1:0] unit_total;
  logic          unit_we;

  // Request decode, done at acceptance.
  logic [XW-1:0]         pos_x;
  logic [XW-1:0]         left_x;
  logic [XW-1:0]         right_x;
  logic [XW-1:0]         hi_x;
  logic [XW-1:0]         end_x;
  logic [NW-1:0]         nv_x;
  logic                  pos_ok;
  logic                  range_empty;
  logic                  accept;
  logic                  out_free;
  logic                  in_win;
  logic [XW-1:0]         total_x;

  // Window step selection.
  logic                  step_any;
  logic [PW-1:0]         step_pos;
  rdcw_pkg::cnt_op_e     step_op;
  logic [PW-1:0]         step_low;
  logic [CW-1:0]         step_end;
  logic [PW-1:0]         win_low_m1;
  logic [CW-1:0]         win_end_m1;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  assign pos_x   = XW'(position_i);
  assign left_x  = XW'(range_left_i);
  assign right_x = XW'(range_right_i);
  assign nv_x    = NW'(new_value_i);
  assign pos_ok  = (pos_x < XW'(ARRAY_SIZE));
  // A right edge past the array saturates to its last position.
  assign hi_x        = (right_x >= XW'(ARRAY_SIZE)) ? XW'(ARRAY_SIZE - 1) : right_x;
  assign end_x       = hi_x + XW'(1);
  assign range_empty = (left_x > hi_x);

  assign in_win  = (pos_q >= win_low_q) && (CW'(pos_q) < win_end_q);
  assign total_x = XW'(total_q);

  assign win_low_m1 = win_low_q - PW'(1);
  assign win_end_m1 = win_end_q - CW'(1);

  // The window first grows on the right, then on the left, then shrinks on
  // the right and finally on the left, so a count never drops below zero.
  always_comb begin
    step_any = 1'b1;
    step_pos = win_low_q;
    step_op  = rdcw_pkg::CNT_ADD;
    step_low = win_low_q;
    step_end = win_end_q;
    if (win_end_q < end_q) begin
      step_pos = win_end_q[PW-1:0];
      step_end = win_end_q + CW'(1);
    end else if (win_low_q > lo_q) begin
      step_pos = win_low_m1;
      step_low = win_low_m1;
    end else if (win_end_q > end_q) begin
      step_pos = win_end_m1[PW-1:0];
      step_end = win_end_m1;
      step_op  = rdcw_pkg::CNT_REMOVE;
    end else if (win_low_q < lo_q) begin
      step_pos = win_low_q;
      step_low = win_low_q + PW'(1);
      step_op  = rdcw_pkg::CNT_REMOVE;
    end else begin
      step_any = 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      rdcw_pkg::S_CLEAR: begin
        if (&clr_idx_q) begin
          state_d = rdcw_pkg::S_IDLE;
        end
      end
      rdcw_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == rdcw_pkg::REQ_QUERY) begin
            state_d = range_empty ? rdcw_pkg::S_OUT : rdcw_pkg::S_WALK;
          end else if (pos_ok) begin
            state_d = rdcw_pkg::S_WSTART;
          end
        end
      end
      rdcw_pkg::S_WSTART: begin
        state_d = in_win ? rdcw_pkg::S_ELEM : rdcw_pkg::S_IDLE;
      end
      rdcw_pkg::S_WALK: begin
        state_d = step_any ? rdcw_pkg::S_ELEM : rdcw_pkg::S_OUT;
      end
      rdcw_pkg::S_ELEM: begin
        state_d = rdcw_pkg::S_OCC;
      end
      rdcw_pkg::S_OCC: begin
        if (is_query_q) begin
          state_d = rdcw_pkg::S_WALK;
        end else if (op_q == rdcw_pkg::CNT_REMOVE) begin
          state_d = rdcw_pkg::S_WADD;
        end else begin
          state_d = rdcw_pkg::S_IDLE;
        end
      end
      rdcw_pkg::S_WADD: begin
        state_d = rdcw_pkg::S_OCC;
      end
      rdcw_pkg::S_OUT: begin
        if (out_free) begin
          state_d = rdcw_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rdcw_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath controls and register next values.
  always_comb begin
    in_ready_o  = 1'b0;
    clr_idx_d   = clr_idx_q;
    is_query_d  = is_query_q;
    pos_d       = pos_q;
    val_d       = val_q;
    lo_d        = lo_q;
    end_d       = end_q;
    res_zero_d  = res_zero_q;
    win_low_d   = win_low_q;
    win_end_d   = win_end_q;
    total_d     = total_q;
    op_d        = op_q;
    cur_val_d   = cur_val_q;
    out_valid_d = out_valid_q && !out_ready_i;
    dcount_d    = dcount_q;
    elem_we     = 1'b0;
    elem_waddr  = pos_q;
    elem_wdata  = val_q;
    elem_raddr  = pos_q;
    occ_we      = 1'b0;
    occ_waddr   = cur_val_q;
    occ_wdata   = unit_cnt;
    occ_raddr   = cur_val_q;
    case (state_q)
      rdcw_pkg::S_CLEAR: begin
        occ_we    = 1'b1;
        occ_waddr = clr_idx_q;
        occ_wdata = '0;
        clr_idx_d = clr_idx_q + VALUE_BITS'(1);
      end
      rdcw_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          is_query_d = (req_type_i == rdcw_pkg::REQ_QUERY);
          pos_d      = pos_x[PW-1:0];
          val_d      = nv_x[VALUE_BITS-1:0];
          lo_d       = left_x[PW-1:0];
          end_d      = end_x[CW-1:0];
          res_zero_d = range_empty;
        end
      end
      rdcw_pkg::S_WSTART: begin
        if (in_win) begin
          // Take the old value out before the store is overwritten.
          elem_raddr = pos_q;
          op_d       = rdcw_pkg::CNT_REMOVE;
        end else begin
          elem_we = 1'b1;
        end
      end
      rdcw_pkg::S_WALK: begin
        if (step_any) begin
          elem_raddr = step_pos;
          op_d       = step_op;
          win_low_d  = step_low;
          win_end_d  = step_end;
        end
      end
      rdcw_pkg::S_ELEM: begin
        occ_raddr = elem_rdata;
        cur_val_d = elem_rdata;
      end
      rdcw_pkg::S_OCC: begin
        occ_we  = unit_we;
        total_d = unit_total;
      end
      rdcw_pkg::S_WADD: begin
        elem_we   = 1'b1;
        occ_raddr = val_q;
        cur_val_d = val_q;
        op_d      = rdcw_pkg::CNT_ADD;
      end
      rdcw_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          dcount_d    = res_zero_q ? '0 : total_x[rdcw_pkg::COUNT_FIELD_W-1:0];
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rdcw_pkg::S_CLEAR;
      clr_idx_q   <= '0;
      win_low_q   <= '0;
      win_end_q   <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      win_low_q   <= win_low_d;
      win_end_q   <= win_end_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_query_q <= is_query_d;
    pos_q      <= pos_d;
    val_q      <= val_d;
    lo_q       <= lo_d;
    end_q      <= end_d;
    res_zero_q <= res_zero_d;
    op_q       <= op_d;
    cur_val_q  <= cur_val_d;
    dcount_q   <= dcount_d;
  end

  assign out_valid_o      = out_valid_q;
  assign distinct_count_o = dcount_q;

  rdcw_count_unit #(
    .CW (CW)
  ) u_count_unit (
    .op_i    (op_q),
    .cnt_i   (occ_rdata),
    .total_i (total_q),
    .cnt_o   (unit_cnt),
    .total_o (unit_total),
    .we_o    (unit_we)
  );

  // Element store: never cleared; every position must be written before use, which the block does not enforce.
  rdcw_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (ARRAY_SIZE)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (elem_we),
    .waddr_i (elem_waddr),
    .wdata_i (elem_wdata),
    .raddr_i (elem_raddr),
    .rdata_o (elem_rdata)
  );

  // Occurrence table, cleared by the pass after reset.
  rdcw_ram #(
    .WIDTH (CW),
    .DEPTH (VALUE_COUNT)
  ) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (occ_we),
    .waddr_i (occ_waddr),
    .wdata_i (occ_wdata),
    .raddr_i (occ_raddr),
    .rdata_o (occ_rdata)
  );

endmodule

/* hdl/rdcw_ram.sv */
module rdcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/rdcw_count_unit.sv */
module rdcw_count_unit #(
  parameter int unsigned CW = 11
) (
  input  rdcw_pkg::cnt_op_e op_i,
  input  logic [CW-1:0]     cnt_i,
  input  logic [CW-1:0]     total_i,
  output logic [CW-1:0]     cnt_o,
  output logic [CW-1:0]     total_o,
  output logic              we_o
);

  logic cnt_zero;
  logic cnt_one;

  assign cnt_zero = (cnt_i == '0);
  assign cnt_one  = (cnt_i == CW'(1));

  // Adding a value that was absent raises the distinct total; removing its
  // last occurrence lowers it. Removing an absent value changes nothing.
  always_comb begin
    cnt_o   = cnt_i;
    total_o = total_i;
    we_o    = 1'b0;
    case (op_i)
      rdcw_pkg::CNT_ADD: begin
        cnt_o = cnt_i + CW'(1);
        we_o  = 1'b1;
        if (cnt_zero) begin
          total_o = total_i + CW'(1);
        end
      end
      rdcw_pkg::CNT_REMOVE: begin
        if (!cnt_zero) begin
          cnt_o = cnt_i - CW'(1);
          we_o  = 1'b1;
          if (cnt_one) begin
            total_o = total_i - CW'(1);
          end
        end
      end
      default: begin
        we_o = 1'b0;
      end
    endcase
  end

endmodule
